// File: design/stq_pkg.sv
// Shared types, constants and control codes of the sorted timer event queue.
`default_nettype none

package stq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PEND_W      = 5;

  // Field widths
  localparam int TIME_W = 32;
  localparam int DUR_W  = 31;
  localparam int TAG_W  = 16;

  // Input item
  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] now_seconds;
    logic [DUR_W-1:0]  duration;
    logic [TAG_W-1:0]  event_tag;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic              fired;
    logic [TAG_W-1:0]  fired_tag;
    logic [TIME_W-1:0] fired_start;
    logic [DUR_W-1:0]  fired_duration;
    logic [TIME_W-1:0] fired_expiry;
    logic              add_dropped;
    logic [PEND_W-1:0] pending_count;
  } result_t;

  // One stored event
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] start;
    logic [DUR_W-1:0]  duration;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Item modes
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_CMP,
    ST_ADD_LAST,
    ST_TICK_CMP
  } stq_state_e;

  // Memory read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_KM1,
    RD_KM2
  } rd_sel_e;

  // Memory write source select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_NEW,
    WR_MOVE
  } wr_sel_e;

  // Sequencer to datapath
  typedef struct packed {
    logic    latch_item;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    k_dec;
    logic    finish;
    logic    fire;
    logic    dropped;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic k_zero;
    logic k_one;
    logic greater;
  } status_t;

endpackage

`default_nettype wire

// File: design/stq_entry_mem.sv
// Event storage: one write port and one registered read port.
`default_nettype none

module stq_entry_mem (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [stq_pkg::IDX_W-1:0] wr_addr_i,
  input  wire stq_pkg::entry_t           wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [stq_pkg::IDX_W-1:0] rd_addr_i,
  output stq_pkg::entry_t                rd_data_o
);

  stq_pkg::entry_t mem_q [stq_pkg::QUEUE_DEPTH];
  stq_pkg::entry_t rd_data_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/stq_seq.sv
// Sequencer that steps the shared compare unit through an insert walk or a pop.
`default_nettype none

module stq_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire stq_pkg::status_t status_i,
  output stq_pkg::ctrl_t        ctrl_o,
  output logic                  busy
);

  stq_pkg::stq_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stq_pkg::ST_IDLE: begin
        if (start) state_d = stq_pkg::ST_DISPATCH;
      end
      stq_pkg::ST_DISPATCH: begin
        if (status_i.is_tick) begin
          state_d = status_i.empty ? stq_pkg::ST_IDLE : stq_pkg::ST_TICK_CMP;
        end else if (status_i.full || status_i.k_zero) begin
          state_d = stq_pkg::ST_IDLE;
        end else begin
          state_d = stq_pkg::ST_ADD_CMP;
        end
      end
      stq_pkg::ST_ADD_CMP: begin
        if (!status_i.greater) begin
          state_d = stq_pkg::ST_IDLE;
        end else if (status_i.k_one) begin
          state_d = stq_pkg::ST_ADD_LAST;
        end
      end
      stq_pkg::ST_ADD_LAST: state_d = stq_pkg::ST_IDLE;
      stq_pkg::ST_TICK_CMP: state_d = stq_pkg::ST_IDLE;
      default:              state_d = stq_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl_o = '{latch_item: 1'b0, rd_sel: stq_pkg::RD_NONE, wr_sel: stq_pkg::WR_NONE,
               k_dec: 1'b0, finish: 1'b0, fire: 1'b0, dropped: 1'b0};
    unique case (state_q)
      stq_pkg::ST_IDLE: begin
        ctrl_o.latch_item = start;
      end
      stq_pkg::ST_DISPATCH: begin
        if (status_i.is_tick) begin
          if (status_i.empty) ctrl_o.finish = 1'b1;
          else                ctrl_o.rd_sel = stq_pkg::RD_HEAD;
        end else if (status_i.full) begin
          ctrl_o.finish  = 1'b1;
          ctrl_o.dropped = 1'b1;
        end else if (status_i.k_zero) begin
          ctrl_o.wr_sel = stq_pkg::WR_NEW;
          ctrl_o.finish = 1'b1;
        end else begin
          ctrl_o.rd_sel = stq_pkg::RD_KM1;
        end
      end
      stq_pkg::ST_ADD_CMP: begin
        // Later expiry moves up one slot; otherwise the new event lands here
        if (status_i.greater) begin
          ctrl_o.wr_sel = stq_pkg::WR_MOVE;
          ctrl_o.k_dec  = 1'b1;
          if (!status_i.k_one) ctrl_o.rd_sel = stq_pkg::RD_KM2;
        end else begin
          ctrl_o.wr_sel = stq_pkg::WR_NEW;
          ctrl_o.finish = 1'b1;
        end
      end
      stq_pkg::ST_ADD_LAST: begin
        ctrl_o.wr_sel = stq_pkg::WR_NEW;
        ctrl_o.finish = 1'b1;
      end
      stq_pkg::ST_TICK_CMP: begin
        ctrl_o.finish = 1'b1;
        ctrl_o.fire   = !status_i.greater;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != stq_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: design/sorted_timer_event_queue.sv
// Top level of the sorted timer event queue: pointers, compare unit and result register.
// A ring of QUEUE_DEPTH events is kept sorted by expiry, earliest at the head.
// An item is taken when start is high and busy is low; busy then stays high while
// the item is worked. Its result appears on result_o for exactly one cycle with
// result_valid_o high, in the first cycle that busy is low again, and must be taken
// then since the receiver cannot stall it; the next item may be taken in that same
// cycle. A tick holds busy through dispatch with the head read and a compare state,
// or dispatch alone on an empty queue. An add holds it through dispatch and a compare
// state per stored entry with a later expiry, each moved up one slot per cycle
// through the single read and write port of the event memory; the new event is
// written where the walk stops, or in a last state once the head entry has moved.
// An add ends at dispatch when the queue is full or empty, and at worst all
// QUEUE_DEPTH - 1 stored entries move. One magnitude comparator serves both the
// insert walk and the expiry test. The memory needs no clearing after reset.
`default_nettype none

module sorted_timer_event_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire stq_pkg::in_item_t in_i,
  output logic                   result_valid_o,
  output stq_pkg::result_t       result_o
);

  localparam int IDX_W = stq_pkg::IDX_W;
  localparam int CNT_W = stq_pkg::CNT_W;

  stq_pkg::ctrl_t   ctrl;
  stq_pkg::status_t status;

  stq_pkg::in_item_t item_q;
  logic [stq_pkg::TIME_W-1:0] exp_q, exp_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  stq_pkg::result_t result_q, result_d;
  logic             valid_q;

  logic [stq_pkg::TIME_W:0] exp_sum;
  logic [CNT_W-1:0]         k_m1, k_m2;
  logic [IDX_W-1:0]         rd_addr, wr_addr;
  logic                     rd_en, wr_en;
  stq_pkg::entry_t          new_entry, wr_data, rd_data;
  logic [stq_pkg::TIME_W-1:0] cmp_b;
  logic [CNT_W+stq_pkg::PEND_W-1:0] pend_ext;

  // Map a queue offset to a ring slot
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W+1)'(stq_pkg::QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(stq_pkg::QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  stq_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  // Saturating expiry of the incoming event
  assign exp_sum = {1'b0, in_i.now_seconds} + {2'b00, in_i.duration};
  assign exp_d   = exp_sum[stq_pkg::TIME_W] ? '1 : exp_sum[stq_pkg::TIME_W-1:0];

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (ctrl.latch_item) begin
      item_q <= in_i;
      exp_q  <= exp_d;
    end
  end

  // Shared compare unit: stored expiry against new expiry or current time
  assign cmp_b          = (item_q.mode == stq_pkg::MODE_TICK) ? item_q.now_seconds : exp_q;
  assign status.greater = (rd_data.expiry > cmp_b);
  assign status.is_tick = (item_q.mode == stq_pkg::MODE_TICK);
  assign status.full    = (count_q >= CNT_W'(stq_pkg::QUEUE_DEPTH));
  assign status.empty   = (count_q == '0);
  assign status.k_zero  = (k_q == '0);
  assign status.k_one   = (k_q == CNT_W'(1));

  // Memory addressing
  assign k_m1 = k_q - CNT_W'(1);
  assign k_m2 = k_q - CNT_W'(2);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = head_q;
    case (ctrl.rd_sel)
      stq_pkg::RD_HEAD: rd_addr = head_q;
      stq_pkg::RD_KM1:  rd_addr = slot(head_q, k_m1[IDX_W-1:0]);
      stq_pkg::RD_KM2:  rd_addr = slot(head_q, k_m2[IDX_W-1:0]);
      default:          rd_en   = 1'b0;
    endcase
  end

  assign new_entry = '{expiry: exp_q, start: item_q.now_seconds,
                       duration: item_q.duration, tag: item_q.event_tag};
  assign wr_en     = (ctrl.wr_sel != stq_pkg::WR_NONE);
  assign wr_addr   = slot(head_q, k_q[IDX_W-1:0]);
  assign wr_data   = (ctrl.wr_sel == stq_pkg::WR_MOVE) ? rd_data : new_entry;

  stq_entry_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Advance pointers and fill count
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    k_d     = k_q;
    if (ctrl.latch_item) k_d = count_q;
    if (ctrl.k_dec)      k_d = k_m1;
    if (ctrl.fire) begin
      count_d = count_q - CNT_W'(1);
      head_d  = (head_q == IDX_W'(stq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
    end
    if (ctrl.finish && (ctrl.wr_sel == stq_pkg::WR_NEW)) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      k_q     <= k_d;
      valid_q <= ctrl.finish;
    end
  end

  // Build the result transfer
  assign pend_ext = {{stq_pkg::PEND_W{1'b0}}, count_d};

  always_comb begin
    result_d                = '0;
    result_d.fired          = ctrl.fire;
    result_d.add_dropped    = ctrl.dropped;
    result_d.pending_count  = pend_ext[stq_pkg::PEND_W-1:0];
    if (ctrl.fire) begin
      result_d.fired_tag      = rd_data.tag;
      result_d.fired_start    = rd_data.start;
      result_d.fired_duration = rd_data.duration;
      result_d.fired_expiry   = rd_data.expiry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

`ifndef ASSERT_OFF
  // Fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(stq_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  // A result is shown only once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A fire and a drop never come from the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.fired) |-> !result_o.add_dropped)
    else $error("fired and dropped together");
`endif

endmodule

`default_nettype wire

// File: tb/sorted_timer_event_queue_tb.sv
// Self-checking testbench of the sorted timer event queue, with a scoreboard class.
`default_nettype none

module sorted_timer_event_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 850;
  localparam int CALM_ITEMS   = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = stq_pkg::QUEUE_DEPTH + 10;

  // Scoreboard: tracks the pending timers and the results they will produce
  class expiry_scoreboard;
    stq_pkg::entry_t  pending_events[$];
    stq_pkg::result_t expected_results[$];
    int               mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Apply one accepted transfer to the timer list and queue its outcome
    function void note_item(stq_pkg::in_item_t item);
      stq_pkg::result_t res;
      stq_pkg::entry_t  ev;
      logic [32:0]      sum;
      int               pos;
      res = '0;
      if (item.mode == stq_pkg::MODE_ADD) begin
        if (pending_events.size() >= stq_pkg::QUEUE_DEPTH) begin
          res.add_dropped = 1'b1;
        end else begin
          sum = {1'b0, item.now_seconds} + {2'b00, item.duration};
          ev.expiry   = sum[32] ? '1 : sum[31:0];
          ev.start    = item.now_seconds;
          ev.duration = item.duration;
          ev.tag      = item.event_tag;
          // Land after every entry of equal or earlier expiry
          pos = 0;
          while (pos < pending_events.size() && pending_events[pos].expiry <= ev.expiry)
            pos++;
          pending_events.insert(pos, ev);
        end
      end else if (pending_events.size() > 0 &&
                   pending_events[0].expiry <= item.now_seconds) begin
        ev = pending_events.pop_front();
        res.fired          = 1'b1;
        res.fired_tag      = ev.tag;
        res.fired_start    = ev.start;
        res.fired_duration = ev.duration;
        res.fired_expiry   = ev.expiry;
      end
      res.pending_count = stq_pkg::PEND_W'(pending_events.size());
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    // Compare one result transfer against the oldest expectation
    function void check_result(stq_pkg::result_t got);
      stq_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("fired", 32'(want.fired), 32'(got.fired));
      compare_field("fired_tag", 32'(want.fired_tag), 32'(got.fired_tag));
      compare_field("fired_start", want.fired_start, got.fired_start);
      compare_field("fired_duration", 32'(want.fired_duration), 32'(got.fired_duration));
      compare_field("fired_expiry", want.fired_expiry, got.fired_expiry);
      compare_field("add_dropped", 32'(want.add_dropped), 32'(got.add_dropped));
      compare_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  stq_pkg::in_item_t in_i;
  logic              result_valid_o;
  stq_pkg::result_t  result_o;

  expiry_scoreboard sb;
  int               cycle_count = 0;
  logic [31:0]      wall_seconds;
  int               add_bias;

  sorted_timer_event_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watch both transfer points; results are checked before a new item is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.note_item(in_i);
    end
  end

  // Hard stop on a hung block
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic stq_pkg::in_item_t make_add(logic [31:0] now, logic [30:0] dur,
                                                 logic [15:0] tag);
    stq_pkg::in_item_t it;
    it.mode        = stq_pkg::MODE_ADD;
    it.now_seconds = now;
    it.duration    = dur;
    it.event_tag   = tag;
    return it;
  endfunction

  function automatic stq_pkg::in_item_t make_tick(logic [31:0] now);
    stq_pkg::in_item_t it;
    it.mode        = stq_pkg::MODE_TICK;
    it.now_seconds = now;
    it.duration    = 31'($urandom);
    it.event_tag   = 16'($urandom);
    return it;
  endfunction

  // Build one random item around the running wall clock
  function automatic stq_pkg::in_item_t random_item();
    stq_pkg::in_item_t it;
    logic [31:0]       now;
    logic [30:0]       dur;
    int                r;
    r = $urandom_range(99);
    if (r < 85) now = wall_seconds;
    else if (r < 95) now = $urandom;
    else now = 32'hFFFF_FFFF - $urandom_range(40);
    r = $urandom_range(99);
    if (r < 70) dur = 31'($urandom_range(30));
    else if (r < 88) dur = 31'($urandom);
    else dur = 31'h7FFF_FFFF - 31'($urandom_range(3));
    if ($urandom_range(99) < add_bias) it = make_add(now, dur, 16'($urandom));
    else it = make_tick(now);
    return it;
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_item(stq_pkg::in_item_t item);
    @(negedge clk_i);
    start = 1'b1;
    in_i  = item;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a few cycles with junk on the item bus
  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
      in_i  = stq_pkg::in_item_t'(80'({$urandom, $urandom, $urandom}));
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    wall_seconds = 32'd0;
    add_bias     = 50;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty tick, exact-equality fire, saturation, ordering, late ticks
    send_item(make_tick(32'd0));
    send_item(make_add(32'd0, 31'd0, 16'h0000));
    send_item(make_tick(32'd0));
    send_item(make_add(32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF));
    send_item(make_add(32'd10, 31'd5, 16'd1));
    send_item(make_add(32'd12, 31'd3, 16'd2));
    send_item(make_add(32'd0, 31'd15, 16'd3));
    send_item(make_tick(32'd14));
    repeat (3) send_item(make_tick(32'd100));
    send_item(make_tick(32'd100));
    send_item(make_tick(32'hFFFF_FFFF));

    // Fill the queue, then overflow it
    for (int k = 0; k < stq_pkg::QUEUE_DEPTH; k++)
      send_item(make_add(32'd1000 + k, 31'($urandom_range(50)), 16'(k + 16'h0100)));
    send_item(make_add(32'd1020, 31'd2, 16'hBEEF));
    idle_for(3);
    wait_drained();
    wall_seconds = 32'd1000;

    // Random: the wall clock creeps forward, the add/tick mix shifts by phase
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 120 == 0) begin
        case ((i / 120) % 4)
          0: add_bias = 75;
          1: add_bias = 25;
          2: add_bias = 90;
          default: add_bias = 50;
        endcase
      end
      if ($urandom_range(99) == 0) wall_seconds = $urandom;
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(3) == 0)
        idle_for($urandom_range(1, 7));
      send_item(random_item());
      wall_seconds = wall_seconds + $urandom_range(3);
    end

    // Wind down: wait out the last results, then the block's latency
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/stq_pkg.sv
design/stq_entry_mem.sv
design/stq_seq.sv
design/sorted_timer_event_queue.sv
tb/sorted_timer_event_queue_tb.sv
